FILE: rtl/dfa_string_recognizer_defines.svh
// Assertion helpers used by the checker file of the recogniser.
`ifndef DFA_STRING_RECOGNIZER_DEFINES_SVH
`define DFA_STRING_RECOGNIZER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DSR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define DSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/dfa_pkg.sv
`default_nettype none

package dfa_pkg;

    localparam int MAX_STATES_DEF  = 16;
    localparam int MAX_SYMBOLS_DEF = 8;

    localparam int STATE_W = 4;
    localparam int COL_W   = 3;
    localparam int CHAR_W  = 8;
    localparam int FUNC_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int MASK_W     = 16;
    localparam int ASIZE_W    = 4;

    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_BEGIN = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FEED  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_START_STATE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_MASK    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_CHARS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_SIZE  = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [STATE_W-1:0] row_state;
        logic [COL_W-1:0]   column_symbol;
        logic [STATE_W-1:0] next_state;
        logic [CHAR_W-1:0]  symbol_char;
    } dfa_in_t;

    typedef struct packed {
        logic [STATE_W-1:0] current_state;
        logic               accepted;
        logic               symbol_unknown;
    } dfa_out_t;

endpackage

`default_nettype wire

FILE: rtl/dfa_ram.sv
`default_nettype none

module dfa_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/dfa_string_recognizer.sv
`default_nettype none
// Table-driven finite automaton recogniser.
// Command channel: a transaction is taken at a rising edge with start high and busy low.
//   func selects a transition entry write, a string begin or a symbol feed.
// Configuration: cfg_write with cfg_index and cfg_data writes one register at once;
//   the user must change registers only while the block is idle; the block does not enforce this.
// An entry write completes in the accepting cycle and gives no result; the next
//   transaction may follow in the very next cycle.
// A begin or feed gives one result, strobed by done in the cycle after acceptance.
//   busy is high in that cycle, so no new transaction is taken while a result is shown.
//   This follows from the registered read of the transition memory, whose output is
//   the next state that the following symbol must address.
// Results cannot be held off: done is high for exactly one cycle per result.
// Reset clears the present state, the dead flag and the configuration registers to
//   their reset values; transition entries hold nothing defined until written.
module dfa_string_recognizer #(
    parameter int MAX_STATES  = dfa_pkg::MAX_STATES_DEF,
    parameter int MAX_SYMBOLS = dfa_pkg::MAX_SYMBOLS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire dfa_pkg::dfa_in_t                   request,
    output logic                                    done,
    output dfa_pkg::dfa_out_t                       result,
    input  wire logic                               cfg_write,
    input  wire logic [dfa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [dfa_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int SYM_W    = $clog2(MAX_SYMBOLS);
    localparam int SYM_SPAN = 1 << SYM_W;
    localparam int DEPTH    = MAX_STATES * SYM_SPAN;
    localparam int ADDR_W   = $clog2(DEPTH);

    typedef struct packed {
        logic is_feed;
        logic known;
        logic in_range;
    } pend_t;

    logic [dfa_pkg::STATE_W-1:0]    start_state_reg;
    logic [dfa_pkg::MASK_W-1:0]     accept_mask_reg;
    logic [dfa_pkg::CFG_DATA_W-1:0] alphabet_chars_reg;
    logic [dfa_pkg::ASIZE_W-1:0]    alphabet_size_reg;

    logic [dfa_pkg::STATE_W-1:0] present_state_reg, present_state_next;
    logic                        dead_reg, dead_next;
    logic                        pending_reg, pending_next;
    pend_t                       pend_reg, pend_next;

    logic              accept;
    logic              sym_hit;
    logic [SYM_W-1:0]  sym_idx;
    logic              tbl_we;
    logic [ADDR_W-1:0] tbl_waddr;
    logic [ADDR_W-1:0] tbl_raddr;
    logic [dfa_pkg::STATE_W-1:0] tbl_rdata;
    logic [dfa_pkg::STATE_W-1:0] out_state;

    assign accept = start && !pending_reg;
    assign busy   = pending_reg;
    assign done   = pending_reg;

    // Alphabet search: the lowest matching symbol index wins.
    always_comb
    begin
        sym_hit = 1'b0;
        sym_idx = '0;
        for (int k = MAX_SYMBOLS - 1; k >= 0; k--)
        begin
            if (int'(alphabet_size_reg) > k &&
                request.symbol_char == alphabet_chars_reg[8*k +: 8])
            begin
                sym_hit = 1'b1;
                sym_idx = SYM_W'(k);
            end
        end
    end

    assign tbl_we = accept && request.func == dfa_pkg::FUNC_WRITE &&
                    int'(request.row_state) < MAX_STATES &&
                    int'(request.column_symbol) < MAX_SYMBOLS;
    assign tbl_waddr = ADDR_W'({request.row_state, request.column_symbol[SYM_W-1:0]});
    assign tbl_raddr = ADDR_W'({present_state_reg, sym_idx});

    dfa_ram #(
        .WIDTH (dfa_pkg::STATE_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (request.next_state),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    always_comb
    begin
        present_state_next = present_state_reg;
        dead_next          = dead_reg;
        pending_next       = 1'b0;
        pend_next          = pend_reg;
        if (pending_reg)
        begin
            if (pend_reg.is_feed && pend_reg.known && pend_reg.in_range)
            begin
                present_state_next = tbl_rdata;
            end
        end
        else if (accept)
        begin
            unique case (request.func)
                dfa_pkg::FUNC_BEGIN:
                begin
                    present_state_next = start_state_reg;
                    dead_next          = 1'b0;
                    pending_next       = 1'b1;
                    pend_next          = '{is_feed: 1'b0, known: 1'b1, in_range: 1'b0};
                end
                dfa_pkg::FUNC_FEED:
                begin
                    pending_next = 1'b1;
                    pend_next.is_feed  = 1'b1;
                    pend_next.known    = sym_hit;
                    pend_next.in_range = int'(present_state_reg) < MAX_STATES;
                    if (!sym_hit)
                    begin
                        dead_next = 1'b1;
                    end
                end
                dfa_pkg::FUNC_WRITE, dfa_pkg::FUNC_SPARE:
                begin
                    pending_next = 1'b0;
                end
                default:
                begin
                    pending_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_state_reg <= '0;
            dead_reg          <= 1'b0;
            pending_reg       <= 1'b0;
            pend_reg          <= '0;
        end
        else
        begin
            present_state_reg <= present_state_next;
            dead_reg          <= dead_next;
            pending_reg       <= pending_next;
            pend_reg          <= pend_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_state_reg    <= '0;
            accept_mask_reg    <= '0;
            alphabet_chars_reg <= '0;
            alphabet_size_reg  <= dfa_pkg::ASIZE_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                dfa_pkg::REG_START_STATE:
                    start_state_reg <= cfg_data[dfa_pkg::STATE_W-1:0];
                dfa_pkg::REG_ACCEPT_MASK:
                    accept_mask_reg <= cfg_data[dfa_pkg::MASK_W-1:0];
                dfa_pkg::REG_ALPHABET_CHARS:
                    alphabet_chars_reg <= cfg_data;
                dfa_pkg::REG_ALPHABET_SIZE:
                    alphabet_size_reg <= cfg_data[dfa_pkg::ASIZE_W-1:0];
                default:
                    alphabet_size_reg <= alphabet_size_reg;
            endcase
        end
    end

    // The stepped state is shown straight from the memory output in the result cycle.
    assign out_state = (pend_reg.is_feed && pend_reg.known && pend_reg.in_range) ?
                       tbl_rdata : present_state_reg;

    assign result.current_state  = out_state;
    assign result.accepted       = accept_mask_reg[out_state] && !dead_reg;
    assign result.symbol_unknown = pend_reg.is_feed && !pend_reg.known;

endmodule

`default_nettype wire

FILE: rtl/dfa_checker.sv
`default_nettype none
`include "dfa_string_recognizer_defines.svh"

module dfa_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire dfa_pkg::dfa_in_t  request,
    input wire logic              done,
    input wire dfa_pkg::dfa_out_t result
);

    logic take_result;
    logic take_silent;

    assign take_result = start && !busy &&
                         (request.func == dfa_pkg::FUNC_BEGIN ||
                          request.func == dfa_pkg::FUNC_FEED);
    assign take_silent = start && !busy &&
                         (request.func == dfa_pkg::FUNC_WRITE ||
                          request.func == dfa_pkg::FUNC_SPARE);

    `DSR_ASSERT_NEXT(a_result_follows, clk, rst_n, take_result, done, "begin or feed gave no result")
    `DSR_ASSERT_NEXT(a_write_silent, clk, rst_n, take_silent, !done, "write transaction gave a result")
    `DSR_ASSERT_NEXT(a_single_strobe, clk, rst_n, done, !done, "two results in consecutive cycles")
    `DSR_ASSERT_SAME(a_busy_on_done, clk, rst_n, done, busy, "transaction taken while a result is shown")
    `DSR_ASSERT_SAME(a_unknown_rejects, clk, rst_n, done && result.symbol_unknown, !result.accepted, "unknown character reported as accepted")

endmodule

bind dfa_string_recognizer dfa_checker u_dfa_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
);

`default_nettype wire
